@@ rtl/lvw_pkg.sv @@
package lvw_pkg;

    localparam int COORD_BITS  = 6;
    localparam int NUM_AXES    = 3;
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS);
    localparam int MAG_W       = COORD_BITS + 1;
    localparam int ERR_W       = MAG_W + 2;
    localparam int NXT_W       = COORD_BITS + 2;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_X_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Z_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Z_HIGH = 3'd5;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef coord_t [NUM_AXES-1:0] point_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef struct packed {
        point_t low;
        point_t high;
    } box_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic step;
    } dp_cmd_t;

    typedef struct packed {
        logic start_in_box;
        logic run_last;
    } dp_status_t;

endpackage

@@ rtl/lvw_cfg.sv @@
module lvw_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lvw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  lvw_pkg::coord_t                     cfg_data,
    output lvw_pkg::box_t                       box
);
    import lvw_pkg::*;

    box_t box_reg;
    box_t box_next;

    assign cfg_ready = 1'b1;
    assign box       = box_reg;

    always_comb
    begin
        box_next = box_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_X_LOW:  box_next.low[AXIS_X]  = cfg_data;
                REG_X_HIGH: box_next.high[AXIS_X] = cfg_data;
                REG_Y_LOW:  box_next.low[AXIS_Y]  = cfg_data;
                REG_Y_HIGH: box_next.high[AXIS_Y] = cfg_data;
                REG_Z_LOW:  box_next.low[AXIS_Z]  = cfg_data;
                REG_Z_HIGH: box_next.high[AXIS_Z] = cfg_data;
                default:    box_next = box_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg.low  <= '0;
            box_reg.high <= '1;
        end
        else
        begin
            box_reg <= box_next;
        end
    end

endmodule

@@ rtl/lvw_ctrl.sv @@
module lvw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output logic                  voxel_valid,
    output lvw_pkg::dp_cmd_t      cmd,
    input  lvw_pkg::dp_status_t   status
);
    import lvw_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SETUP = 3'b010,
        ST_RUN   = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        busy        = 1'b1;
        voxel_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = status.start_in_box ? ST_RUN : ST_IDLE;
            end
            ST_RUN:
            begin
                voxel_valid = 1'b1;
                if (status.run_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/lvw_dp.sv @@
module lvw_dp (
    input  logic                  clk,
    input  lvw_pkg::dp_cmd_t      cmd,
    input  lvw_pkg::box_t         box,
    input  lvw_pkg::point_t       start_pt,
    input  lvw_pkg::point_t       end_pt,
    output lvw_pkg::dp_status_t   status,
    output lvw_pkg::point_t       voxel,
    output logic                  last,
    output logic                  clipped
);
    import lvw_pkg::*;

    coord_t                  cur_reg  [NUM_AXES];
    coord_t                  fin_reg  [NUM_AXES];
    logic                    neg_reg  [NUM_AXES];
    logic                    nz_reg   [NUM_AXES];
    logic [MAG_W-1:0]        mag2_reg [NUM_AXES];
    logic signed [ERR_W-1:0] err_reg  [NUM_AXES];
    axis_t                   dom_reg;
    logic [CNT_W-1:0]        cnt_reg;

    axis_t                   dom_next;
    logic signed [ERR_W-1:0] err_init [NUM_AXES];
    logic signed [ERR_W-1:0] err_step [NUM_AXES];
    logic signed [NXT_W-1:0] nxt      [NUM_AXES];
    logic [MAG_W-1:0]        mag      [NUM_AXES];
    logic                    cur_in_box;
    logic                    nxt_in_box;
    logic                    at_end;
    logic                    clip;

    // load: deltas, directions and doubled magnitudes
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            if (end_pt[i] < start_pt[i])
            begin
                mag[i] = {1'b0, start_pt[i] - end_pt[i]};
            end
            else
            begin
                mag[i] = {1'b0, end_pt[i] - start_pt[i]};
            end
        end
    end

    // setup: dominant axis and initial error terms
    always_comb
    begin
        priority if (mag2_reg[AXIS_X] >= mag2_reg[AXIS_Y] &&
                     mag2_reg[AXIS_X] >= mag2_reg[AXIS_Z])
        begin
            dom_next = AXIS_X;
        end
        else if (mag2_reg[AXIS_Y] >= mag2_reg[AXIS_Z])
        begin
            dom_next = AXIS_Y;
        end
        else
        begin
            dom_next = AXIS_Z;
        end
        for (int i = 0; i < NUM_AXES; i++)
        begin
            err_init[i] = $signed({2'b00, mag2_reg[i]})
                        - $signed({3'b000, mag2_reg[dom_next][MAG_W-1:1]});
        end
    end

    // walk step
    always_comb
    begin
        cur_in_box = 1'b1;
        nxt_in_box = 1'b1;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            nxt[i]      = $signed({2'b00, cur_reg[i]});
            err_step[i] = err_reg[i];
            if (i == int'(dom_reg))
            begin
                if (nz_reg[i])
                begin
                    nxt[i] = neg_reg[i] ? nxt[i] - NXT_W'(1) : nxt[i] + NXT_W'(1);
                end
            end
            else
            begin
                if (!err_reg[i][ERR_W-1])
                begin
                    if (nz_reg[i])
                    begin
                        nxt[i] = neg_reg[i] ? nxt[i] - NXT_W'(1) : nxt[i] + NXT_W'(1);
                    end
                    err_step[i] = err_reg[i] - $signed({2'b00, mag2_reg[dom_reg]});
                end
                err_step[i] = err_step[i] + $signed({2'b00, mag2_reg[i]});
            end
            if (cur_reg[i] < box.low[i] || cur_reg[i] > box.high[i])
            begin
                cur_in_box = 1'b0;
            end
            if (nxt[i] < $signed({2'b00, box.low[i]}) ||
                nxt[i] > $signed({2'b00, box.high[i]}))
            begin
                nxt_in_box = 1'b0;
            end
        end
    end

    assign at_end  = (cur_reg[dom_reg] == fin_reg[dom_reg]);
    assign clip    = (cnt_reg == CNT_W'(MAX_RESULTS - 1)) || !nxt_in_box;
    assign last    = at_end || clip;
    assign clipped = !at_end && clip;

    assign status.start_in_box = cur_in_box;
    assign status.run_last     = last;

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            voxel[i] = cur_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                cur_reg[i]  <= start_pt[i];
                fin_reg[i]  <= end_pt[i];
                neg_reg[i]  <= (end_pt[i] < start_pt[i]);
                nz_reg[i]   <= (end_pt[i] != start_pt[i]);
                mag2_reg[i] <= {mag[i][MAG_W-2:0], 1'b0};
            end
            cnt_reg <= '0;
        end
        else if (cmd.setup)
        begin
            dom_reg <= dom_next;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                err_reg[i] <= err_init[i];
            end
        end
        else if (cmd.step)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                cur_reg[i] <= nxt[i][COORD_BITS-1:0];
                err_reg[i] <= err_step[i];
            end
            cnt_reg <= cnt_reg + {{(CNT_W-1){1'b0}}, 1'b1};
        end
    end

endmodule

@@ rtl/line_voxel_walker_3d_unit.sv @@
// a request is taken in idle, the setup state follows, then the run state emits one voxel per cycle
// busy is high through the setup state and the run state; the walk steps after each voxel but the last
// a new request is taken only while busy is low, so a request is finished before the next one is taken
// a start point outside the clip box gives no voxels and holds busy for the setup state only
// the receiver cannot stall: each voxel is on the ports for one cycle only
// rst_n (async, active low) idles the controller and opens the clip box to full range
module line_voxel_walker_3d_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  lvw_pkg::coord_t                start_x,
    input  lvw_pkg::coord_t                start_y,
    input  lvw_pkg::coord_t                start_z,
    input  lvw_pkg::coord_t                end_x,
    input  lvw_pkg::coord_t                end_y,
    input  lvw_pkg::coord_t                end_z,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lvw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  lvw_pkg::coord_t                cfg_data,
    output logic                           voxel_valid,
    output lvw_pkg::coord_t                voxel_x,
    output lvw_pkg::coord_t                voxel_y,
    output lvw_pkg::coord_t                voxel_z,
    output logic                           last,
    output logic                           clipped
);
    import lvw_pkg::*;

    box_t       box;
    dp_cmd_t    cmd;
    dp_status_t status;
    point_t     start_pt;
    point_t     end_pt;
    point_t     voxel;

    assign start_pt = {start_z, start_y, start_x};
    assign end_pt   = {end_z, end_y, end_x};
    assign voxel_x  = voxel[AXIS_X];
    assign voxel_y  = voxel[AXIS_Y];
    assign voxel_z  = voxel[AXIS_Z];

    lvw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .box       (box)
    );

    lvw_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .voxel_valid (voxel_valid),
        .cmd         (cmd),
        .status      (status)
    );

    lvw_dp u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .box      (box),
        .start_pt (start_pt),
        .end_pt   (end_pt),
        .status   (status),
        .voxel    (voxel),
        .last     (last),
        .clipped  (clipped)
    );

    // request taken: setup cycle emits nothing
    a_setup_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !voxel_valid)
        else $error("voxel emitted in setup cycle");

    // a run emits without gaps until its last voxel
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        (voxel_valid && !last) |=> voxel_valid)
        else $error("gap inside a run");

    // block goes idle right after the last voxel
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (voxel_valid && last) |=> !busy)
        else $error("busy after last voxel");

    a_clipped_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (voxel_valid && clipped) |-> last)
        else $error("clipped set on a voxel that is not last");

endmodule

@@ test/line_voxel_walker_3d_unit_test.sv @@
`timescale 1ns / 1ps

module line_voxel_walker_3d_unit_test;
    import lvw_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
    localparam int RANDOM_LINES = 470;
    localparam int RANDOM_PHASES = 8;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   last;
        logic   clipped;
    } voxel_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    coord_t               start_x;
    coord_t               start_y;
    coord_t               start_z;
    coord_t               end_x;
    coord_t               end_y;
    coord_t               end_z;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    coord_t               cfg_data;
    logic                 voxel_valid;
    coord_t               voxel_x;
    coord_t               voxel_y;
    coord_t               voxel_z;
    logic                 last;
    logic                 clipped;

    box_t   clip_box;
    voxel_t expected_voxels[$];
    int     fail_count = 0;

    line_voxel_walker_3d_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .start_x     (start_x),
        .start_y     (start_y),
        .start_z     (start_z),
        .end_x       (end_x),
        .end_y       (end_y),
        .end_z       (end_z),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .voxel_valid (voxel_valid),
        .voxel_x     (voxel_x),
        .voxel_y     (voxel_y),
        .voxel_z     (voxel_z),
        .last        (last),
        .clipped     (clipped)
    );

    always #5 clk = ~clk;

    function automatic bit point_in_box(input int p[3]);
        int  i;
        bit  inside_all;
        inside_all = 1'b1;
        for (i = 0; i < NUM_AXES; i++)
        begin
            if (p[i] < int'(clip_box.low[i]) || p[i] > int'(clip_box.high[i]))
                inside_all = 1'b0;
        end
        return inside_all;
    endfunction

    function automatic void push_voxel(input int p[3], input logic is_last,
                                       input logic is_clipped);
        voxel_t v;
        v.x       = coord_t'(p[0]);
        v.y       = coord_t'(p[1]);
        v.z       = coord_t'(p[2]);
        v.last    = is_last;
        v.clipped = is_clipped;
        expected_voxels = {expected_voxels, v};
    endfunction

    // bresenham walk from the start point toward the end point, cut at the clip box or at MAX_RESULTS voxels
    function automatic void predict_line_voxels(input coord_t sx, input coord_t sy,
                                                input coord_t sz, input coord_t ex,
                                                input coord_t ey, input coord_t ez);
        int    cur[3];
        int    nxt[3];
        int    fin[3];
        int    mag2[3];
        int    dir[3];
        int    err[3];
        int    d;
        int    i;
        int    n;
        int    dom;
        axis_t dom_axis;
        bit    done;
        cur = '{int'(sx), int'(sy), int'(sz)};
        fin = '{int'(ex), int'(ey), int'(ez)};
        for (i = 0; i < NUM_AXES; i++)
        begin
            d = fin[i] - cur[i];
            dir[i] = (d < 0) ? -1 : ((d > 0) ? 1 : 0);
            mag2[i] = ((d < 0) ? -d : d) * 2;
        end
        if (mag2[0] >= mag2[1] && mag2[0] >= mag2[2])
            dom_axis = AXIS_X;
        else if (mag2[1] >= mag2[2])
            dom_axis = AXIS_Y;
        else
            dom_axis = AXIS_Z;
        dom = int'(dom_axis);
        for (i = 0; i < NUM_AXES; i++)
            err[i] = mag2[i] - mag2[dom] / 2;
        if (!point_in_box(cur))
            return;
        n = 0;
        done = 1'b0;
        while (!done)
        begin
            if (cur[dom] == fin[dom])
            begin
                push_voxel(cur, 1'b1, 1'b0);
                done = 1'b1;
            end
            else
            begin
                for (i = 0; i < NUM_AXES; i++)
                begin
                    nxt[i] = cur[i];
                    if (i != dom)
                    begin
                        if (err[i] >= 0)
                        begin
                            nxt[i] += dir[i];
                            err[i] -= mag2[dom];
                        end
                        err[i] += mag2[i];
                    end
                end
                nxt[dom] += dir[dom];
                if (n == MAX_RESULTS - 1 || !point_in_box(nxt))
                begin
                    push_voxel(cur, 1'b1, 1'b1);
                    done = 1'b1;
                end
                else
                begin
                    push_voxel(cur, 1'b0, 1'b0);
                    n++;
                    cur = nxt;
                end
            end
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : voxel_checker
        voxel_t want;
        if (rst_n && voxel_valid)
        begin
            if (expected_voxels.size() == 0)
            begin
                $display("%0t: unexpected voxel, expected none, actual (%0d,%0d,%0d)",
                         $time, voxel_x, voxel_y, voxel_z);
                fail_count++;
            end
            else
            begin
                want = expected_voxels.pop_front();
                check_field("voxel_x", want.x, voxel_x);
                check_field("voxel_y", want.y, voxel_y);
                check_field("voxel_z", want.z, voxel_z);
                check_field("last", want.last, last);
                check_field("clipped", want.clipped, clipped);
            end
        end
    end

    task automatic send_line(input coord_t sx, input coord_t sy, input coord_t sz,
                             input coord_t ex, input coord_t ey, input coord_t ez);
        start   <= 1'b1;
        start_x <= sx;
        start_y <= sy;
        start_z <= sz;
        end_x   <= ex;
        end_y   <= ey;
        end_z   <= ez;
        do
            @(posedge clk);
        while (busy);
        predict_line_voxels(sx, sy, sz, ex, ey, ez);
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_voxels.size() != 0 || busy)
            @(posedge clk);
        // a request with no voxels may still be in flight
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input coord_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_X_LOW:  clip_box.low[AXIS_X]  = data;
            REG_X_HIGH: clip_box.high[AXIS_X] = data;
            REG_Y_LOW:  clip_box.low[AXIS_Y]  = data;
            REG_Y_HIGH: clip_box.high[AXIS_Y] = data;
            REG_Z_LOW:  clip_box.low[AXIS_Z]  = data;
            REG_Z_HIGH: clip_box.high[AXIS_Z] = data;
            default: ;
        endcase
    endtask

    task automatic set_clip_box(input coord_t xl, input coord_t xh, input coord_t yl,
                                input coord_t yh, input coord_t zl, input coord_t zh);
        wait_drained();
        write_reg(REG_X_LOW, xl);
        write_reg(REG_X_HIGH, xh);
        write_reg(REG_Y_LOW, yl);
        write_reg(REG_Y_HIGH, yh);
        write_reg(REG_Z_LOW, zl);
        write_reg(REG_Z_HIGH, zh);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_lines();
        send_line(0, 0, 0, 63, 63, 63);
        send_line(63, 63, 63, 0, 0, 0);
        send_line(5, 5, 5, 5, 5, 5);
        idle_gap(3);
        send_line(0, 0, 0, 63, 0, 0);
        send_line(0, 63, 0, 0, 0, 0);
        send_line(0, 0, 0, 0, 0, 63);
        // ties on the dominant delta
        send_line(10, 10, 0, 20, 20, 7);
        send_line(0, 10, 10, 3, 20, 20);
        send_line(10, 0, 10, 20, 3, 0);
        idle_gap(12);
        send_line(0, 63, 0, 63, 0, 63);
        send_line(63, 0, 31, 0, 63, 32);
        send_line(1, 2, 3, 40, 17, 60);
        send_line(63, 63, 63, 63, 63, 63);
        send_line(0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_clip_box();
        set_clip_box(10, 50, 5, 40, 0, 63);
        send_line(5, 20, 20, 30, 20, 20);
        send_line(20, 20, 20, 63, 20, 20);
        send_line(20, 20, 20, 0, 0, 0);
        send_line(10, 5, 0, 50, 40, 63);
        // empty box
        set_clip_box(40, 20, 0, 63, 0, 63);
        send_line(30, 30, 30, 35, 10, 2);
        send_line(0, 0, 0, 63, 63, 63);
        // single voxel boxes, one inside and one at each extreme
        set_clip_box(7, 7, 7, 7, 7, 7);
        send_line(7, 7, 7, 7, 7, 7);
        send_line(7, 7, 7, 8, 8, 8);
        set_clip_box(0, 0, 0, 0, 0, 0);
        send_line(0, 0, 0, 63, 1, 2);
        set_clip_box(63, 63, 63, 63, 63, 63);
        send_line(63, 63, 63, 0, 62, 61);
    endtask

    task automatic test_spare_registers();
        set_clip_box(0, 63, 0, 63, 0, 63);
        wait_drained();
        write_reg(REG_SPARE_6, 6'd0);
        write_reg(REG_SPARE_7, 6'd63);
        cfg_valid <= 1'b0;
        send_line(0, 31, 63, 63, 32, 0);
    endtask

    function automatic void pick_bounds(output coord_t lo, output coord_t hi);
        int r;
        coord_t a;
        coord_t b;
        r = $urandom_range(99, 0);
        a = coord_t'($urandom_range(63, 0));
        b = coord_t'($urandom_range(63, 0));
        if (r < 45)
        begin
            lo = 0;
            hi = 63;
        end
        else if (r < 90)
        begin
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
        end
        else if (r < 96)
        begin
            lo = a;
            hi = a;
        end
        else
        begin
            lo = a;
            hi = b;
        end
    endfunction

    function automatic coord_t pick_inside(input coord_t lo, input coord_t hi);
        if (lo <= hi)
            return coord_t'($urandom_range(hi, lo));
        else
            return coord_t'($urandom_range(63, 0));
    endfunction

    function automatic coord_t pick_near(input coord_t c);
        int v;
        v = int'(c) + int'($urandom_range(12, 0)) - 6;
        if (v < 0)
            v = 0;
        if (v > 63)
            v = 63;
        return coord_t'(v);
    endfunction

    task automatic test_random_lines();
        coord_t lo[3];
        coord_t hi[3];
        coord_t s[3];
        coord_t e[3];
        int     phase;
        int     k;
        int     i;
        int     mode;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            for (i = 0; i < NUM_AXES; i++)
            begin
                if (phase == 0)
                begin
                    lo[i] = 0;
                    hi[i] = 63;
                end
                else
                    pick_bounds(lo[i], hi[i]);
            end
            set_clip_box(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
            for (k = 0; k < RANDOM_LINES / RANDOM_PHASES; k++)
            begin
                mode = $urandom_range(99, 0);
                for (i = 0; i < NUM_AXES; i++)
                begin
                    if (mode < 25)
                    begin
                        s[i] = coord_t'($urandom_range(63, 0));
                        e[i] = coord_t'($urandom_range(63, 0));
                    end
                    else if (mode < 80)
                    begin
                        s[i] = pick_inside(lo[i], hi[i]);
                        e[i] = coord_t'($urandom_range(63, 0));
                    end
                    else
                    begin
                        s[i] = pick_inside(lo[i], hi[i]);
                        e[i] = pick_near(s[i]);
                    end
                end
                if ($urandom_range(99, 0) < 3)
                    wait_drained();
                else
                    idle_gap(pick_gap());
                send_line(s[0], s[1], s[2], e[0], e[1], e[2]);
            end
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        start_x   <= '0;
        start_y   <= '0;
        start_z   <= '0;
        end_x     <= '0;
        end_y     <= '0;
        end_z     <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        clip_box.low  = '0;
        clip_box.high = '1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_lines();
        test_clip_box();
        test_spare_registers();
        test_random_lines();
        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
